// ===== rtl/touch_contact_slot_tracker_defines.svh =====
// assertion macros shared by the checker of this project
`ifndef TOUCH_CONTACT_SLOT_TRACKER_DEFINES_SVH
`define TOUCH_CONTACT_SLOT_TRACKER_DEFINES_SVH

// same-cycle implication, sampled on the rising clock edge
`define TCST_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tcst check failed");

// next-cycle implication, sampled on the rising clock edge
`define TCST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tcst check failed");

`endif

// ===== rtl/tcst_pkg.sv =====
`default_nettype none

package tcst_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 11;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned SLOT_W = 4;
  localparam int unsigned KIND_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PRESS   = 2'd0,
    CMD_MOVE    = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    EV_DOWN = 2'd0,
    EV_MOVE = 2'd1,
    EV_UP   = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  // table write request
  typedef struct packed {
    logic en;
    logic busy;
  } tbl_wr_t;

  // compare result for the slot under the scan pointer
  typedef struct packed {
    logic busy;
    logic match;
  } tbl_stat_t;

endpackage

`default_nettype wire

// ===== rtl/tcst_slot_table.sv =====
`default_nettype none

module tcst_slot_table #(
  parameter int unsigned NUM_SLOTS = tcst_pkg::NUM_SLOTS_DEF,
  parameter int unsigned IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [IDX_W-1:0]          rd_idx_i,
  input  wire logic [tcst_pkg::ID_W-1:0] key_i,
  output tcst_pkg::tbl_stat_t            stat_o,
  input  wire tcst_pkg::tbl_wr_t         wr_i,
  input  wire logic [IDX_W-1:0]          wr_idx_i
);

  logic [NUM_SLOTS-1:0]      busy_q;
  logic [tcst_pkg::ID_W-1:0] owner_q [NUM_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else if (wr_i.en) begin
      busy_q[wr_idx_i] <= wr_i.busy;
    end
  end

  // owner only written on a claim
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.busy) begin
      owner_q[wr_idx_i] <= key_i;
    end
  end

  // the one shared comparator
  always_comb begin
    stat_o.busy  = busy_q[rd_idx_i];
    stat_o.match = busy_q[rd_idx_i] && (owner_q[rd_idx_i] == key_i);
  end

endmodule

`default_nettype wire

// ===== rtl/touch_contact_slot_tracker.sv =====
`default_nettype none

// touch contact slot tracker: keeps up to NUM_SLOTS touch or pointer contacts
// in a slot table. a press for an id not yet held claims the lowest free slot
// and gives a down beat; a move for a held id gives a move beat unless it
// comes from a mouse with the left button up; a release frees the slot and
// gives an up beat. presses for held ids, presses with the table full, unused
// command codes and moves or releases for unknown ids give no result beat.
// after acceptance, one owner comparator walks the table a slot per cycle,
// then the apply state applies the outcome; only then can the next item be
// accepted. the result waits in an output register, so a new item can be
// taken while it is still stalled; the apply cycle of that next item is held
// for as long as the earlier result beat stays stalled.

module touch_contact_slot_tracker #(
  parameter int unsigned NUM_SLOTS = tcst_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input beats
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [tcst_pkg::CMD_W-1:0]  cmd_i,
  input  wire logic [tcst_pkg::ID_W-1:0]   contact_id_i,
  input  wire logic signed [tcst_pkg::POS_W-1:0] pos_x_i,
  input  wire logic signed [tcst_pkg::POS_W-1:0] pos_y_i,
  input  wire logic                        from_mouse_i,
  input  wire logic                        left_held_i,
  // result beats
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [tcst_pkg::SLOT_W-1:0]      slot_o,
  output logic [tcst_pkg::KIND_W-1:0]      event_kind_o,
  output logic signed [tcst_pkg::POS_W-1:0] out_x_o,
  output logic signed [tcst_pkg::POS_W-1:0] out_y_o
);

  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  tcst_pkg::state_e state_q, state_d;

  // captured input beat
  logic [tcst_pkg::CMD_W-1:0]  cmd_q;
  logic [tcst_pkg::ID_W-1:0]   id_q;
  logic signed [tcst_pkg::POS_W-1:0] x_q, y_q;
  logic                        mouse_q, left_q;

  // scan pointer and what the walk has found so far
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             hit_q, hit_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic             free_q, free_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;

  // output register
  logic                        out_valid_q, out_valid_d;
  logic [tcst_pkg::SLOT_W-1:0] slot_q;
  logic [tcst_pkg::KIND_W-1:0] kind_q;
  logic signed [tcst_pkg::POS_W-1:0] ox_q, oy_q;

  // decision made in the apply cycle
  logic                        in_acc;
  logic                        apply_go;
  logic                        emit;
  tcst_pkg::event_e            emit_kind;
  logic [IDX_W-1:0]            emit_idx;
  tcst_pkg::tbl_wr_t           tbl_wr;
  tcst_pkg::tbl_stat_t         tbl_stat;

  tcst_slot_table #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (idx_q),
    .key_i    (id_q),
    .stat_o   (tbl_stat),
    .wr_i     (tbl_wr),
    .wr_idx_i (emit_idx)
  );

  assign in_acc = in_valid_i && !in_stall_o;

  // the outcome can only leave once the output register is free or draining
  assign apply_go = (state_q == tcst_pkg::ST_APPLY) && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tcst_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = tcst_pkg::ST_SCAN;
      end
      tcst_pkg::ST_SCAN: begin
        if (idx_q == LAST_IDX) state_d = tcst_pkg::ST_APPLY;
      end
      tcst_pkg::ST_APPLY: begin
        if (apply_go) state_d = tcst_pkg::ST_IDLE;
      end
      default: state_d = tcst_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    unique case (state_q)
      tcst_pkg::ST_IDLE:  in_stall_o = 1'b0;
      tcst_pkg::ST_SCAN:  in_stall_o = 1'b1;
      tcst_pkg::ST_APPLY: in_stall_o = 1'b1;
      default:            in_stall_o = 1'b1;
    endcase
  end

  // scan bookkeeping: lowest matching busy slot and lowest free slot
  always_comb begin
    idx_d      = idx_q;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    if (in_acc) begin
      idx_d  = '0;
      hit_d  = 1'b0;
      free_d = 1'b0;
    end else if (state_q == tcst_pkg::ST_SCAN) begin
      if (tbl_stat.match && !hit_q) begin
        hit_d     = 1'b1;
        hit_idx_d = idx_q;
      end
      if (!tbl_stat.busy && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = idx_q;
      end
      if (idx_q != LAST_IDX) idx_d = idx_q + 1'b1;
    end
  end

  // what the finished walk means for this command
  always_comb begin
    emit      = 1'b0;
    emit_kind = tcst_pkg::EV_DOWN;
    emit_idx  = hit_idx_q;
    tbl_wr    = '0;
    case (cmd_q)
      tcst_pkg::CMD_PRESS: begin
        emit_idx = free_idx_q;
        if (!hit_q && free_q) begin
          emit        = 1'b1;
          emit_kind   = tcst_pkg::EV_DOWN;
          tbl_wr.en   = apply_go;
          tbl_wr.busy = 1'b1;
        end
      end
      tcst_pkg::CMD_MOVE: begin
        // stored position is never read back, so only the event matters
        if (hit_q && !(mouse_q && !left_q)) begin
          emit      = 1'b1;
          emit_kind = tcst_pkg::EV_MOVE;
        end
      end
      tcst_pkg::CMD_RELEASE: begin
        if (hit_q) begin
          emit        = 1'b1;
          emit_kind   = tcst_pkg::EV_UP;
          tbl_wr.en   = apply_go;
          tbl_wr.busy = 1'b0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign out_valid_d = apply_go ? emit : (out_valid_q && out_stall_i);

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcst_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (in_acc) begin
      cmd_q   <= cmd_i;
      id_q    <= contact_id_i;
      x_q     <= pos_x_i;
      y_q     <= pos_y_i;
      mouse_q <= from_mouse_i;
      left_q  <= left_held_i;
    end
    if (apply_go && emit) begin
      // slot field keeps the low bits of the index
      slot_q <= tcst_pkg::SLOT_W'(emit_idx);
      kind_q <= emit_kind;
      ox_q   <= x_q;
      oy_q   <= y_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign slot_o       = slot_q;
  assign event_kind_o = kind_q;
  assign out_x_o      = ox_q;
  assign out_y_o      = oy_q;

endmodule

`default_nettype wire

// ===== rtl/tcst_checker.sv =====
`default_nettype none

`include "touch_contact_slot_tracker_defines.svh"

module tcst_checker #(
  parameter int unsigned NUM_SLOTS = tcst_pkg::NUM_SLOTS_DEF
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire logic [tcst_pkg::SLOT_W-1:0] slot_o,
  input wire logic [tcst_pkg::KIND_W-1:0] event_kind_o,
  input wire logic [tcst_pkg::POS_W-1:0]  out_x_o,
  input wire logic [tcst_pkg::POS_W-1:0]  out_y_o
);

  // a stalled result beat stays put
  `TCST_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(slot_o) && $stable(event_kind_o) && $stable(out_x_o) && $stable(out_y_o))

  // an accepted item keeps the block busy for the walk
  `TCST_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // a fresh result only follows a busy cycle
  `TCST_ASSERT_NOW(a_result_after_work, clk_i, rst_ni, $rose(out_valid_o), $past(in_stall_o))

  // result beats carry a real event and a slot within the table
  `TCST_ASSERT_NOW(a_result_legal, clk_i, rst_ni, out_valid_o, (event_kind_o == tcst_pkg::EV_DOWN || event_kind_o == tcst_pkg::EV_MOVE || event_kind_o == tcst_pkg::EV_UP) && (NUM_SLOTS > 16 || slot_o < NUM_SLOTS))

endmodule

bind touch_contact_slot_tracker tcst_checker #(.NUM_SLOTS(NUM_SLOTS)) u_tcst_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .slot_o       (slot_o),
  .event_kind_o (event_kind_o),
  .out_x_o      (out_x_o),
  .out_y_o      (out_y_o)
);

`default_nettype wire

// ===== test/tb_touch_contact_slot_tracker.sv =====
module tb_touch_contact_slot_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  // package names used below
  localparam int unsigned NUM_SLOTS_DEF = tcst_pkg::NUM_SLOTS_DEF;
  localparam int unsigned CMD_W  = tcst_pkg::CMD_W;
  localparam int unsigned ID_W   = tcst_pkg::ID_W;
  localparam int unsigned POS_W  = tcst_pkg::POS_W;
  localparam int unsigned SLOT_W = tcst_pkg::SLOT_W;
  localparam int unsigned KIND_W = tcst_pkg::KIND_W;

  typedef tcst_pkg::event_e event_e;

  localparam tcst_pkg::cmd_e CMD_PRESS   = tcst_pkg::CMD_PRESS;
  localparam tcst_pkg::cmd_e CMD_MOVE    = tcst_pkg::CMD_MOVE;
  localparam tcst_pkg::cmd_e CMD_RELEASE = tcst_pkg::CMD_RELEASE;
  localparam event_e         EV_DOWN     = tcst_pkg::EV_DOWN;
  localparam event_e         EV_MOVE     = tcst_pkg::EV_MOVE;
  localparam event_e         EV_UP       = tcst_pkg::EV_UP;

  // command code that the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // one item walks the table a slot per cycle, then applies the outcome
  localparam int SCAN_CYCLES = NUM_SLOTS_DEF + 2;
  // cycles without any accepted beat before the run is called dead
  localparam int HANG_LIMIT  = 3000;
  // contact ids that the random part mostly draws from; more ids than slots
  // so the table keeps running full
  localparam int ID_POOL     = 14;
  localparam int PHASE_ITEMS = 310;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic [ID_W-1:0]         id;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    mouse;
    logic                    left;
  } touch_beat_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       slot;
    event_e                  kind;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } touch_event_t;

  // one row of the directed part: the beat, and where the outcome is obvious,
  // the typed-in result (or the absence of one)
  typedef struct packed {
    touch_beat_t  beat;
    logic         given;
    logic         has;
    touch_event_t ev;
  } touch_row_t;

  logic clk;
  logic rst_ni;

  logic                    in_valid;
  logic                    in_stall;
  logic [CMD_W-1:0]        cmd;
  logic [ID_W-1:0]         contact_id;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic                    from_mouse;
  logic                    left_held;

  logic                    out_valid;
  logic                    out_stall;
  logic [SLOT_W-1:0]       slot;
  logic [KIND_W-1:0]       event_kind;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;

  // predictor copy of the slot table
  logic                    held_busy  [NUM_SLOTS_DEF];
  logic [ID_W-1:0]         held_owner [NUM_SLOTS_DEF];
  logic signed [POS_W-1:0] held_x     [NUM_SLOTS_DEF];
  logic signed [POS_W-1:0] held_y     [NUM_SLOTS_DEF];

  touch_event_t    pending_events[$];
  logic [ID_W-1:0] id_pool[ID_POOL];

  int send_idle_pct;
  int recv_stall_pct;
  int errors;
  int quiet_cycles;

  touch_contact_slot_tracker dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .contact_id_i (contact_id),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .from_mouse_i (from_mouse),
    .left_held_i  (left_held),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .slot_o       (slot),
    .event_kind_o (event_kind),
    .out_x_o      (out_x),
    .out_y_o      (out_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // predictor: applies one accepted beat to the table copy and tells whether
  // an event beat comes out of it
  // -------------------------------------------------------------------------
  function automatic bit track_contact(input touch_beat_t b, output touch_event_t ev);
    int hit;
    int free_slot;
    int i;
    hit       = -1;
    free_slot = -1;
    ev        = '0;
    ev.x      = b.x;
    ev.y      = b.y;
    // walk downwards so the lowest matching or free slot is the one left
    for (i = NUM_SLOTS_DEF - 1; i >= 0; i--) begin
      if (held_busy[i] && held_owner[i] == b.id) hit = i;
      if (!held_busy[i]) free_slot = i;
    end
    case (b.cmd)
      CMD_PRESS: begin
        // already held, or no room left: dropped
        if (hit >= 0 || free_slot < 0) return 1'b0;
        held_busy[free_slot]  = 1'b1;
        held_owner[free_slot] = b.id;
        held_x[free_slot]     = b.x;
        held_y[free_slot]     = b.y;
        ev.slot = free_slot[SLOT_W-1:0];
        ev.kind = EV_DOWN;
        return 1'b1;
      end
      CMD_MOVE: begin
        if (hit < 0) return 1'b0;
        held_x[hit] = b.x;
        held_y[hit] = b.y;
        // mouse hovering with the button up: position kept, nothing reported
        if (b.mouse && !b.left) return 1'b0;
        ev.slot = hit[SLOT_W-1:0];
        ev.kind = EV_MOVE;
        return 1'b1;
      end
      CMD_RELEASE: begin
        if (hit < 0) return 1'b0;
        // stored position is left as it was
        held_busy[hit] = 1'b0;
        ev.slot = hit[SLOT_W-1:0];
        ev.kind = EV_UP;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  // -------------------------------------------------------------------------
  // sender: presents one beat from a falling edge, holds it until taken
  // -------------------------------------------------------------------------
  task automatic send_beat(input touch_row_t r);
    touch_event_t ev;
    bit           has;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    cmd        <= r.beat.cmd;
    contact_id <= r.beat.id;
    pos_x      <= r.beat.x;
    pos_y      <= r.beat.y;
    from_mouse <= r.beat.mouse;
    left_held  <= r.beat.left;
    do @(posedge clk); while (in_stall);
    // the predictor always runs so its table tracks the block
    has = track_contact(r.beat, ev);
    if (r.given) begin
      has = r.has;
      ev  = r.ev;
    end
    if (has) pending_events.push_back(ev);
  endtask

  // hold the sender off until every pending event beat has come out
  task automatic drain_events();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
  endtask

  // well-formed traffic on a small id pool, with some stray ids and codes
  task automatic random_beat(output touch_beat_t b);
    int pick;
    pick = $urandom_range(99);
    if (pick < 32)      b.cmd = CMD_PRESS;
    else if (pick < 67) b.cmd = CMD_MOVE;
    else if (pick < 95) b.cmd = CMD_RELEASE;
    else                b.cmd = CMD_UNUSED;
    if ($urandom_range(99) < 88) b.id = id_pool[$urandom_range(ID_POOL - 1)];
    else                         b.id = $urandom;
    b.x     = POS_W'($urandom);
    b.y     = POS_W'($urandom);
    b.mouse = 1'($urandom_range(1));
    b.left  = 1'($urandom_range(1));
  endtask

  function automatic touch_row_t row(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                                     input logic signed [POS_W-1:0] x,
                                     input logic signed [POS_W-1:0] y,
                                     input logic m, input logic l,
                                     input int given, input int has,
                                     input int s, input event_e k);
    touch_row_t r;
    r.beat.cmd   = c;
    r.beat.id    = id;
    r.beat.x     = x;
    r.beat.y     = y;
    r.beat.mouse = m;
    r.beat.left  = l;
    r.given      = given[0];
    r.has        = has[0];
    r.ev.slot    = s[SLOT_W-1:0];
    r.ev.kind    = k;
    r.ev.x       = x;
    r.ev.y       = y;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // receiver: random stall from the falling edge, checks at the rising edge
  // -------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_events
    touch_event_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch("event beat with nothing pending, slot", int'(slot), -1);
      end else begin
        want = pending_events.pop_front();
        if (slot !== want.slot) report_mismatch("slot", int'(slot), int'(want.slot));
        if (event_kind !== want.kind) begin
          report_mismatch("event_kind", int'(event_kind), int'(want.kind));
        end
        if (out_x !== want.x) report_mismatch("out_x", int'(out_x), int'(want.x));
        if (out_y !== want.y) report_mismatch("out_y", int'(out_y), int'(want.y));
      end
    end
  end

  // watchdog on cycles in which neither side moves a beat
  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= HANG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", HANG_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin : main_seq
    touch_row_t  dir_rows[25];
    touch_beat_t b;
    int          count;
    int          phase;
    int          i;

    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    out_stall      = 1'b0;
    cmd            = CMD_PRESS;
    contact_id     = '0;
    pos_x          = '0;
    pos_y          = '0;
    from_mouse     = 1'b0;
    left_held      = 1'b0;
    send_idle_pct  = 9;
    recv_stall_pct = 80;
    errors         = 0;
    quiet_cycles   = 0;
    for (i = 0; i < NUM_SLOTS_DEF; i++) held_busy[i] = 1'b0;
    for (i = 0; i < ID_POOL; i++) id_pool[i] = $urandom;
    // extreme ids stay in play for the random part
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hffff_ffff;

    dir_rows = '{
      // first presses after reset: slots 0 and 1, extreme ids and positions
      row(CMD_PRESS,   32'h0000_0000, 16'sh8000, 16'sh7fff, 1'b0, 1'b0, 1, 1, 0, EV_DOWN),
      row(CMD_PRESS,   32'hffff_ffff, 16'sh7fff, 16'sh8000, 1'b1, 1'b1, 1, 1, 1, EV_DOWN),
      // press for an id already held
      row(CMD_PRESS,   32'h0000_0000, 16'sd100,  16'sd100,  1'b0, 1'b0, 1, 0, 0, EV_DOWN),
      // mouse move with the button up: stored, no beat
      row(CMD_MOVE,    32'h0000_0000, 16'sh1234, -16'sd2,   1'b1, 1'b0, 1, 0, 0, EV_DOWN),
      row(CMD_MOVE,    32'h0000_0000, 16'sh5555, 16'shaaaa, 1'b1, 1'b1, 1, 1, 0, EV_MOVE),
      row(CMD_MOVE,    32'hffff_ffff, 16'shaaaa, 16'sh5555, 1'b0, 1'b0, 1, 1, 1, EV_MOVE),
      // unknown ids
      row(CMD_MOVE,    32'd5,         16'sd3,    16'sd4,    1'b0, 1'b1, 1, 0, 0, EV_DOWN),
      row(CMD_RELEASE, 32'd6,         16'sd3,    16'sd4,    1'b0, 1'b0, 1, 0, 0, EV_DOWN),
      // unused command code
      row(CMD_UNUSED,  32'h0000_0000, 16'sd1,    16'sd2,    1'b1, 1'b1, 1, 0, 0, EV_DOWN),
      // release reports its own position
      row(CMD_RELEASE, 32'h0000_0000, 16'sd7,    -16'sd7,   1'b0, 1'b0, 1, 1, 0, EV_UP),
      // freed slot 0 is the lowest free one again
      row(CMD_PRESS,   32'ha5a5_a5a5, -16'sd1,   16'sd0,    1'b0, 1'b1, 1, 1, 0, EV_DOWN),
      // fill the rest of the table
      row(CMD_PRESS,   32'd100,       16'sd10,   -16'sd10,  1'b0, 1'b0, 0, 0, 0, EV_DOWN),
      row(CMD_PRESS,   32'd101,       16'sd11,   -16'sd11,  1'b0, 1'b0, 0, 0, 0, EV_DOWN),
      row(CMD_PRESS,   32'd102,       16'sd12,   -16'sd12,  1'b1, 1'b0, 0, 0, 0, EV_DOWN),
      row(CMD_PRESS,   32'd103,       16'sd13,   -16'sd13,  1'b0, 1'b1, 0, 0, 0, EV_DOWN),
      row(CMD_PRESS,   32'd104,       16'sd14,   -16'sd14,  1'b0, 1'b0, 0, 0, 0, EV_DOWN),
      row(CMD_PRESS,   32'd105,       16'sd15,   -16'sd15,  1'b1, 1'b1, 0, 0, 0, EV_DOWN),
      row(CMD_PRESS,   32'd106,       16'sd16,   -16'sd16,  1'b0, 1'b0, 0, 0, 0, EV_DOWN),
      row(CMD_PRESS,   32'd107,       16'sd17,   -16'sd17,  1'b0, 1'b0, 0, 0, 0, EV_DOWN),
      row(CMD_PRESS,   32'd108,       16'sd18,   -16'sd18,  1'b0, 1'b0, 0, 0, 0, EV_DOWN),
      // table full: dropped
      row(CMD_PRESS,   32'd200,       16'sd20,   16'sd20,   1'b0, 1'b0, 1, 0, 0, EV_DOWN),
      // free a middle slot and take it again
      row(CMD_RELEASE, 32'd104,       16'sd21,   16'sd21,   1'b0, 1'b0, 0, 0, 0, EV_DOWN),
      row(CMD_PRESS,   32'd201,       16'sd22,   16'sd22,   1'b0, 1'b0, 0, 0, 0, EV_DOWN),
      row(CMD_PRESS,   32'd202,       16'sd23,   16'sd23,   1'b0, 1'b0, 1, 0, 0, EV_DOWN),
      row(CMD_RELEASE, 32'hffff_ffff, 16'sd0,    16'sd0,    1'b1, 1'b1, 1, 1, 1, EV_UP)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) send_beat(dir_rows[k]);
    // pause the sender until the table has answered everything so far
    drain_events();

    // random part: sender mostly busy and receiver slow, then the reverse,
    // then full rate on both sides
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 9;
          recv_stall_pct = 80;
        end
        1: begin
          send_idle_pct  = 80;
          recv_stall_pct = 9;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      count = 0;
      while (count < PHASE_ITEMS) begin
        random_beat(b);
        send_beat({b, 1'b0, 1'b0, touch_event_t'('0)});
        count++;
      end
      drain_events();
    end

    // let any stray beat show up before closing
    repeat (3 * SCAN_CYCLES) @(posedge clk);
    if (errors == 0 && pending_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
